[rtl/core/rrpd_pkg.sv]
package rrpd_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned LEN_W    = 11;
	localparam int unsigned WORD_W   = 16;
	localparam int unsigned KIND_W   = 2;
	localparam int unsigned CNT_W    = 12;
	localparam int unsigned CRC_LEN  = 4;
	localparam int unsigned CAPR_OFS = 16;
	localparam logic [LEN_W-1:0] MAX_FRAME_RST = LEN_W'(1514);

	localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DONE    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_HDR_ERR = 2'd2;

	typedef struct packed {
		logic [KIND_W-1:0] result_kind;
		logic [BYTE_W-1:0] payload_byte;
		logic [LEN_W-1:0]  payload_length;
		logic [WORD_W-1:0] capr_value;
		logic [WORD_W-1:0] header_status;
		logic [WORD_W-1:0] header_total;
	} result_t;

endpackage

[rtl/core/rrpd_core.sv]
module rrpd_core #(
	parameter int unsigned RING_BYTES = 9708
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [rrpd_pkg::LEN_W-1:0]   cfg_data,
	input  logic                         in_fire,
	input  logic [rrpd_pkg::BYTE_W-1:0]  in_byte,
	output logic                         res_valid,
	output rrpd_pkg::result_t            res
);
	import rrpd_pkg::*;

	localparam int unsigned OFS_W = $clog2(RING_BYTES);
	localparam logic [OFS_W-1:0] OFS_LAST = OFS_W'(RING_BYTES - 1);

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_PAYLOAD,
		PH_CRC,
		PH_PAD
	} phase_t;

	phase_t            phase_q, phase_d;
	logic [23:0]       hdr_q, hdr_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [LEN_W-1:0]  total_q, total_d;
	logic [OFS_W-1:0]  ofs_q, ofs_nxt;
	logic              stuck_q, stuck_d;
	logic [1:0]        start_low_q, start_low_d;
	logic [1:0]        pad_q, pad_d;
	logic [LEN_W-1:0]  max_frame_q;

	logic [WORD_W-1:0] status_w, total_w;
	logic [LEN_W:0]    limit_w;
	logic              hdr_bad;
	logic [LEN_W-1:0]  pay_len;
	logic [WORD_W-1:0] capr_w;
	logic [1:0]        pad_new;

	assign ofs_nxt  = (ofs_q == OFS_LAST) ? '0 : ofs_q + 1'b1;
	assign status_w = hdr_q[15:0];
	assign total_w  = {in_byte, hdr_q[23:16]};
	assign limit_w  = {1'b0, max_frame_q} + (LEN_W+1)'(CRC_LEN);
	assign hdr_bad  = !status_w[0] || (total_w < WORD_W'(CRC_LEN))
		|| (total_w > WORD_W'(limit_w));
	assign pay_len  = total_q - LEN_W'(CRC_LEN);
	assign capr_w   = WORD_W'(ofs_nxt) - WORD_W'(CAPR_OFS);
	assign pad_new  = 2'd0 - (start_low_q + total_w[1:0]);

	always_comb begin
		phase_d     = phase_q;
		hdr_d       = hdr_q;
		cnt_d       = cnt_q;
		total_d     = total_q;
		stuck_d     = stuck_q;
		start_low_d = start_low_q;
		pad_d       = pad_q;
		res_valid   = 1'b0;
		res         = '0;
		if (in_fire && !stuck_q) begin
			case (phase_q)
				PH_HEADER: begin
					cnt_d = cnt_q + 1'b1;
					case (cnt_q[1:0])
						2'd0: begin
							hdr_d[7:0]  = in_byte;
							start_low_d = ofs_q[1:0];
						end
						2'd1: hdr_d[15:8]  = in_byte;
						2'd2: hdr_d[23:16] = in_byte;
						default: begin
							cnt_d = '0;
							if (hdr_bad) begin
								stuck_d           = 1'b1;
								res_valid         = 1'b1;
								res.result_kind   = KIND_HDR_ERR;
								res.header_status = status_w;
								res.header_total  = total_w;
							end else begin
								total_d = total_w[LEN_W-1:0];
								pad_d   = pad_new;
								phase_d = (total_w == WORD_W'(CRC_LEN)) ? PH_CRC : PH_PAYLOAD;
							end
						end
					endcase
				end
				PH_PAYLOAD: begin
					cnt_d            = cnt_q + 1'b1;
					res_valid        = 1'b1;
					res.result_kind  = KIND_PAYLOAD;
					res.payload_byte = in_byte;
					if (cnt_d >= CNT_W'(pay_len)) begin
						cnt_d   = '0;
						phase_d = PH_CRC;
					end
				end
				PH_CRC: begin
					cnt_d = cnt_q + 1'b1;
					if (cnt_q == CNT_W'(CRC_LEN - 1)) begin
						cnt_d = '0;
						if (pad_q == 2'd0) begin
							res_valid          = 1'b1;
							res.result_kind    = KIND_DONE;
							res.payload_length = pay_len;
							res.capr_value     = capr_w;
							phase_d            = PH_HEADER;
						end else begin
							phase_d = PH_PAD;
						end
					end
				end
				default: begin
					if (pad_q != 2'd0) begin
						pad_d = pad_q - 1'b1;
					end
					if (pad_d == 2'd0) begin
						res_valid          = 1'b1;
						res.result_kind    = KIND_DONE;
						res.payload_length = pay_len;
						res.capr_value     = capr_w;
						phase_d            = PH_HEADER;
						cnt_d              = '0;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HEADER;
			hdr_q       <= '0;
			cnt_q       <= '0;
			total_q     <= '0;
			ofs_q       <= '0;
			stuck_q     <= 1'b0;
			start_low_q <= '0;
			pad_q       <= '0;
			max_frame_q <= MAX_FRAME_RST;
		end else begin
			if (cfg_we) begin
				max_frame_q <= cfg_data;
			end
			phase_q     <= phase_d;
			hdr_q       <= hdr_d;
			cnt_q       <= cnt_d;
			total_q     <= total_d;
			stuck_q     <= stuck_d;
			start_low_q <= start_low_d;
			pad_q       <= pad_d;
			if (in_fire && !stuck_q) begin
				ofs_q <= ofs_nxt;
			end
		end
	end

endmodule

[rtl/core/rrpd_out_skid.sv]
module rrpd_out_skid (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	input  rrpd_pkg::result_t push_data,
	output logic              full,
	output logic              out_valid,
	input  logic              out_stall,
	output rrpd_pkg::result_t out_data
);
	import rrpd_pkg::*;

	logic    out_valid_q, skid_valid_q;
	result_t out_q, skid_q;
	logic    take;

	assign take      = out_valid_q && !out_stall;
	assign full      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end
		end else if (push_valid) begin
			if (!out_valid_q || take) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				out_q <= skid_q;
			end
		end else if (push_valid) begin
			if (!out_valid_q || take) begin
				out_q <= push_data;
			end else begin
				skid_q <= push_data;
			end
		end
	end

endmodule

[rtl/core/rx_ring_packet_deframer.sv]
// Receive ring deframer. Ring bytes enter one per transaction on the input
// channel (in_valid / in_stall, ring_byte). Each packet's 4-byte header is
// checked; payload bytes come out one per transaction (result_kind payload),
// CRC and alignment padding are dropped, and the packet's last byte yields a
// done transaction with payload_length and capr_value. A bad header yields
// one header-error transaction, after which all bytes are taken and ignored
// until reset.
// Output: each result is registered in the output register (or its skid
// slot). Throughput: one byte per cycle while in_stall is low, set by the
// single decode step between the state registers and the output register.
// Stall: the output register has a one-entry skid slot behind it; in_stall
// rises while that slot is occupied and falls once out_stall drops.
// max_frame_len is written over the cfg channel (cfg_ready is always high)
// and should only change while the block is idle.
// Reset: arst_n clears the parser to the header phase at ring offset zero,
// the stuck state, both output slots, and sets max_frame_len to 1514.
module rx_ring_packet_deframer #(
	parameter int unsigned RING_BYTES = 9708
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [rrpd_pkg::LEN_W-1:0]   max_frame_len,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [rrpd_pkg::BYTE_W-1:0]  ring_byte,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [rrpd_pkg::KIND_W-1:0]  result_kind,
	output logic [rrpd_pkg::BYTE_W-1:0]  payload_byte,
	output logic [rrpd_pkg::LEN_W-1:0]   payload_length,
	output logic [rrpd_pkg::WORD_W-1:0]  capr_value,
	output logic [rrpd_pkg::WORD_W-1:0]  header_status,
	output logic [rrpd_pkg::WORD_W-1:0]  header_total
);
	import rrpd_pkg::*;

	logic    in_fire;
	logic    res_valid;
	result_t res;
	result_t out_data;
	logic    full;

	assign cfg_ready = 1'b1;
	assign in_stall  = full;
	assign in_fire   = in_valid && !in_stall;

	rrpd_core #(
		.RING_BYTES(RING_BYTES)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_data  (max_frame_len),
		.in_fire   (in_fire),
		.in_byte   (ring_byte),
		.res_valid (res_valid),
		.res       (res)
	);

	rrpd_out_skid u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (res_valid),
		.push_data  (res),
		.full       (full),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

	assign result_kind    = out_data.result_kind;
	assign payload_byte   = out_data.payload_byte;
	assign payload_length = out_data.payload_length;
	assign capr_value     = out_data.capr_value;
	assign header_status  = out_data.header_status;
	assign header_total   = out_data.header_total;

endmodule
